[rtl/rbsi_pkg.sv]
`default_nettype none

package rbsi_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;

   localparam int NUM_W       = 34;
   localparam int DEN_W       = 33;
   localparam int QUO_W       = 32;
   localparam int STEPS       = 31;
   localparam int DIV_LATENCY = STEPS + 1;
   localparam int AXES        = 3;

   localparam logic [30:0] MAX_DISTANCE_RESET = 31'h7FFF_FFFF;

   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_z;
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
      logic signed [31:0] dir_z;
      logic signed [31:0] box_center_x;
      logic signed [31:0] box_center_y;
      logic signed [31:0] box_center_z;
      logic [30:0]        box_size_x;
      logic [30:0]        box_size_y;
      logic [30:0]        box_size_z;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [30:0] entry_distance;
   } rsp_type;

   typedef struct packed {
      logic            valid;
      logic [AXES-1:0] neg_lo;
      logic [AXES-1:0] neg_hi;
      logic [AXES-1:0] par;
      logic [AXES-1:0] par_ok;
   } side_type;

endpackage

`default_nettype wire

[rtl/rbsi_div.sv]
`default_nettype none

module rbsi_div #(
   parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        enable,
   input  logic [rbsi_pkg::NUM_W-1:0]  num_mag,
   input  logic [rbsi_pkg::DEN_W-1:0]  den,
   output logic [rbsi_pkg::QUO_W-1:0]  quo
);

   localparam int STEPS = rbsi_pkg::STEPS;
   localparam int DEN_W = rbsi_pkg::DEN_W;
   localparam int NUM_W = rbsi_pkg::NUM_W;
   localparam int SH    = STEPS - FRAC_BITS;
   localparam int CMP_W = DEN_W + SH;
   localparam int XW    = NUM_W + FRAC_BITS;

   logic [XW-1:0]    x;
   logic             ovf_in;
   logic [DEN_W-1:0] rem0_in;

   logic [DEN_W-1:0] rem_ff  [0:STEPS-1];
   logic [DEN_W-1:0] den_ff  [0:STEPS-1];
   logic [STEPS-1:0] bits_ff [0:STEPS-1];
   logic [STEPS-1:0] q_ff    [0:STEPS];
   logic             ovf_ff  [0:STEPS];

   // The quotient saturates at 2^31; below that it needs 31 bits, so the
   // top part of the scaled dividend is the starting remainder.
   always_comb begin
      x       = {num_mag, {FRAC_BITS{1'b0}}};
      ovf_in  = CMP_W'(num_mag) >= (CMP_W'(den) << SH);
      rem0_in = DEN_W'(x[XW-1:STEPS]);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0]  <= rem0_in;
         den_ff[0]  <= den;
         bits_ff[0] <= x[STEPS-1:0];
         q_ff[0]    <= '0;
         ovf_ff[0]  <= ovf_in;
      end
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic [DEN_W+1:0] ext;
      logic [DEN_W+1:0] sub;
      logic             take;
      logic [DEN_W-1:0] rem_next;

      always_comb begin
         ext      = {1'b0, rem_ff[k], bits_ff[k][STEPS-1]};
         sub      = ext - (DEN_W+2)'(den_ff[k]);
         take     = !sub[DEN_W+1];
         rem_next = take ? sub[DEN_W-1:0] : ext[DEN_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            q_ff[k+1]   <= {q_ff[k][STEPS-2:0], take};
            ovf_ff[k+1] <= ovf_ff[k];
         end
      end

      if (k < STEPS-1) begin : g_carry
         always_ff @(posedge clock) begin
            if (enable) begin
               rem_ff[k+1]  <= rem_next;
               den_ff[k+1]  <= den_ff[k];
               bits_ff[k+1] <= {bits_ff[k][STEPS-2:0], 1'b0};
            end
         end
      end
   end

   assign quo = ovf_ff[STEPS] ? {1'b1, {STEPS{1'b0}}} : {1'b0, q_ff[STEPS]};

endmodule

`default_nettype wire

[rtl/ray_box_slab_intersect_unit.sv]
// Ray against axis-aligned box, slab test in signed fixed point.
// Request channel (req_valid, req_stall, req_data) carries one ray and one
// box per transaction; the response channel (rsp_valid, rsp_stall, rsp_data)
// returns the hit flag and entry distance, one response per request, in order.
// The csr port writes max_distance; write it only while no transaction is in
// flight.
// The dividers, then the sign, slab-order, bound and output registers lie
// between acceptance and rsp_*. Throughput is one transaction per cycle
// when not stalled, set by six pipelined restoring dividers, one quotient
// bit per stage over 31 stages. A stalled response freezes the whole pipeline
// and raises req_stall in the same cycle; nothing is lost or repeated.
// Synchronous reset empties the pipeline and sets max_distance to its maximum.
`default_nettype none

module ray_box_slab_intersect_unit #(
   parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rbsi_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rbsi_pkg::rsp_type rsp_data,
   input  logic              csr_write_enable,
   input  logic [30:0]       csr_write_data
);

   localparam int AXES  = rbsi_pkg::AXES;
   localparam int LAT   = rbsi_pkg::DIV_LATENCY;
   localparam logic [32:0] EPS = 33'((2**FRAC_BITS + 999999) / 1000000);

   logic [30:0] max_distance_ff;
   logic        advance;

   logic signed [31:0] org [0:AXES-1];
   logic signed [31:0] dir [0:AXES-1];
   logic signed [31:0] ctr [0:AXES-1];
   logic [30:0]        siz [0:AXES-1];

   logic [rbsi_pkg::NUM_W-1:0] nlo_mag [0:AXES-1];
   logic [rbsi_pkg::NUM_W-1:0] nhi_mag [0:AXES-1];
   logic [rbsi_pkg::DEN_W-1:0] den     [0:AXES-1];
   logic [rbsi_pkg::QUO_W-1:0] qlo     [0:AXES-1];
   logic [rbsi_pkg::QUO_W-1:0] qhi     [0:AXES-1];

   logic [AXES-1:0] neg_lo_w;
   logic [AXES-1:0] neg_hi_w;
   logic [AXES-1:0] par_w;
   logic [AXES-1:0] par_ok_w;

   rbsi_pkg::side_type side_in;
   rbsi_pkg::side_type side_ff [0:LAT-1];

   logic signed [32:0] tlo_ff [0:AXES-1];
   logic signed [32:0] thi_ff [0:AXES-1];
   logic signed [32:0] near_ff [0:AXES-1];
   logic signed [32:0] far_ff  [0:AXES-1];
   logic signed [32:0] tmin_ff, tmax_ff;
   logic signed [32:0] tmin_in, tmax_in;
   logic [AXES-1:0]    par_e_ff;
   logic               ok_e_ff, ok_f_ff, ok_g_ff;
   logic               valid_e_ff, valid_f_ff, valid_g_ff;
   logic               rsp_valid_ff;
   rbsi_pkg::rsp_type  rsp_data_ff;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_distance_ff <= rbsi_pkg::MAX_DISTANCE_RESET;
      end else if (csr_write_enable) begin
         max_distance_ff <= csr_write_data;
      end
   end

   always_comb begin
      org[0] = req_data.origin_x;
      org[1] = req_data.origin_y;
      org[2] = req_data.origin_z;
      dir[0] = req_data.dir_x;
      dir[1] = req_data.dir_y;
      dir[2] = req_data.dir_z;
      ctr[0] = req_data.box_center_x;
      ctr[1] = req_data.box_center_y;
      ctr[2] = req_data.box_center_z;
      siz[0] = req_data.box_size_x;
      siz[1] = req_data.box_size_y;
      siz[2] = req_data.box_size_z;
   end

   always_comb begin
      side_in.valid  = req_valid;
      side_in.neg_lo = neg_lo_w;
      side_in.neg_hi = neg_hi_w;
      side_in.par    = par_w;
      side_in.par_ok = par_ok_w;
   end

   for (genvar a = 0; a < AXES; a++) begin : g_axis
      logic signed [35:0] o2, c2, s2, lo2, hi2, nlo, nhi, alo, ahi;
      logic signed [32:0] dext, dabs;

      // Face positions are kept at doubled scale so half the size is exact.
      always_comb begin
         o2   = {{3{org[a][31]}}, org[a], 1'b0};
         c2   = {{3{ctr[a][31]}}, ctr[a], 1'b0};
         s2   = {5'b0, siz[a]};
         lo2  = c2 - s2;
         hi2  = c2 + s2;
         nlo  = lo2 - o2;
         nhi  = hi2 - o2;
         alo  = nlo[35] ? -nlo : nlo;
         ahi  = nhi[35] ? -nhi : nhi;
         dext = {dir[a][31], dir[a]};
         dabs = dext[32] ? -dext : dext;
         nlo_mag[a] = alo[rbsi_pkg::NUM_W-1:0];
         nhi_mag[a] = ahi[rbsi_pkg::NUM_W-1:0];
         den[a]     = {dabs[31:0], 1'b0};
      end

      assign neg_lo_w[a] = nlo[35] ^ dir[a][31];
      assign neg_hi_w[a] = nhi[35] ^ dir[a][31];
      assign par_w[a]    = dabs < $signed(EPS);
      assign par_ok_w[a] = !(o2 < lo2) && !(o2 > hi2);

      rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_lo (
         .clock   (clock),
         .enable  (advance),
         .num_mag (nlo_mag[a]),
         .den     (den[a]),
         .quo     (qlo[a])
      );

      rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_hi (
         .clock   (clock),
         .enable  (advance),
         .num_mag (nhi_mag[a]),
         .den     (den[a]),
         .quo     (qhi[a])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) begin
            side_ff[i].valid <= 1'b0;
         end
      end else if (advance) begin
         side_ff[0] <= side_in;
         for (int i = 1; i < LAT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // Apply signs, order each slab pair and drop parallel axes, then register the entry and exit bounds.
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int a = 0; a < AXES; a++) begin
            tlo_ff[a] <= side_ff[LAT-1].neg_lo[a] ? -$signed({1'b0, qlo[a]})
                                                  : $signed({1'b0, qlo[a]});
            thi_ff[a] <= side_ff[LAT-1].neg_hi[a] ? -$signed({1'b0, qhi[a]})
                                                  : $signed({1'b0, qhi[a]});
         end
         par_e_ff <= side_ff[LAT-1].par;
         ok_e_ff  <= &(side_ff[LAT-1].par_ok | ~side_ff[LAT-1].par);
         for (int a = 0; a < AXES; a++) begin
            if (par_e_ff[a]) begin
               near_ff[a] <= '0;
               far_ff[a]  <= $signed({2'b0, max_distance_ff});
            end else if (tlo_ff[a] > thi_ff[a]) begin
               near_ff[a] <= thi_ff[a];
               far_ff[a]  <= tlo_ff[a];
            end else begin
               near_ff[a] <= tlo_ff[a];
               far_ff[a]  <= thi_ff[a];
            end
         end
         ok_f_ff <= ok_e_ff;
         tmin_ff <= tmin_in;
         tmax_ff <= tmax_in;
         ok_g_ff <= ok_f_ff;
      end
   end

   always_comb begin
      tmin_in = '0;
      tmax_in = $signed({2'b0, max_distance_ff});
      for (int a = 0; a < AXES; a++) begin
         if (near_ff[a] > tmin_in) begin
            tmin_in = near_ff[a];
         end
         if (far_ff[a] < tmax_in) begin
            tmax_in = far_ff[a];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_e_ff   <= 1'b0;
         valid_f_ff   <= 1'b0;
         valid_g_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_e_ff   <= side_ff[LAT-1].valid;
         valid_f_ff   <= valid_e_ff;
         valid_g_ff   <= valid_f_ff;
         rsp_valid_ff <= valid_g_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (ok_g_ff && !(tmin_ff > tmax_ff)) begin
            rsp_data_ff.hit            <= 1'b1;
            rsp_data_ff.entry_distance <= tmin_ff[30:0];
         end else begin
            rsp_data_ff.hit            <= 1'b0;
            rsp_data_ff.entry_distance <= '0;
         end
      end
   end

endmodule

`default_nettype wire

[rtl/rbsi_checker.sv]
`default_nettype none

module rbsi_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input rbsi_pkg::rsp_type rsp_data
);

   // A reset leaves no response pending on the next cycle.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // The request side only stalls behind a stalled response.
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a stalled response");

   // A missed ray reports zero distance.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.hit) |-> (rsp_data.entry_distance == '0))
      else $error("miss with nonzero entry distance");

   // A stalled response holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed");

endmodule

bind ray_box_slab_intersect_unit rbsi_checker u_rbsi_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
